// File: design/crps_pkg.sv
// Shared constants, types and control words for the Catmull-Rom path smoother.
`timescale 1ns / 1ps
package crps_pkg;

    // Field and register widths.
    localparam int COORD_W    = 32;
    localparam int CFG_W      = 5;
    localparam int NUM_AXES   = 3;
    localparam int MAX_SUBDIV = 16;

    // Sample index, weights and divisor widths (n <= 16, s <= 15).
    localparam int S_W    = 4;
    localparam int S2_W   = 8;
    localparam int N2_W   = 9;
    localparam int WGT_W  = 12;
    localparam int DEN_W  = 14;

    // Polynomial coefficients hold up to twelve times a coordinate.
    localparam int COEF_W = 36;
    localparam int PROD_W = COEF_W + WGT_W + 1;
    localparam int ACC_W  = 50;

    // Divider: 36 quotient bits, remainder always below the divisor.
    localparam int QUO_W  = 36;
    localparam int REM_W  = 13;
    localparam int DIVC_W = 6;
    localparam int RES_W  = QUO_W + 2;

    localparam logic [CFG_W-1:0]  SUBDIV_RST = CFG_W'(3);
    localparam logic [CFG_W-1:0]  N_MAX      = CFG_W'(MAX_SUBDIV);
    localparam logic [CFG_W-1:0]  N_MIN      = CFG_W'(1);
    localparam logic [DIVC_W-1:0] DIV_LAST   = DIVC_W'(QUO_W - 1);
    localparam logic [RES_W-1:0]  QUO_OFS    = RES_W'(1) << (QUO_W - 1);

    typedef logic signed [COORD_W-1:0] t_coord;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_cur;
        logic setup;
        logic seg2;
        logic p0_old;
        logic wgt_a;
        logic wgt_b;
        logic mul2;
        logic mul3;
        logic acc_last;
        logic div_load;
        logic div_step;
        logic s_inc;
        logic emit_sample;
        logic emit_prev;
        logic emit_cur;
        logic run_end;
        logic path_end;
        logic shift;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_sample;
        logic div_last;
        logic out_free;
    } t_dp_stat;

endpackage

// File: design/crps_datapath.sv
// Datapath: point window, coefficient and weight units, per-axis MAC and divider lanes.
`timescale 1ns / 1ps
module crps_datapath import crps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  t_coord           i_pos_x,
    input  t_coord           i_pos_y,
    input  t_coord           i_pos_z,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output t_coord           o_out_x,
    output t_coord           o_out_y,
    output t_coord           o_out_z,
    output logic             o_run_end,
    output logic             o_path_end
);

    // Configuration and effective subdivision count.
    logic [CFG_W-1:0] r_subdiv;
    logic [CFG_W-1:0] n_eff;

    // Point window: entry 0 is the oldest held point.
    t_coord r_hold [3][NUM_AXES];
    t_coord r_cur  [NUM_AXES];

    // Segment coefficients and p1 per axis.
    logic signed [COEF_W-1:0] r_c1 [NUM_AXES];
    logic signed [COEF_W-1:0] r_c2 [NUM_AXES];
    logic signed [COEF_W-1:0] r_c3 [NUM_AXES];
    t_coord                   r_p1 [NUM_AXES];

    // Per-sample weights.
    logic [S_W-1:0]   r_s;
    logic [N2_W-1:0]  r_n2;
    logic [S2_W-1:0]  r_s2;
    logic [WGT_W-1:0] r_w1;
    logic [WGT_W-1:0] r_w2;
    logic [WGT_W-1:0] r_w3;
    logic [DEN_W-1:0] r_den;

    // MAC and divider lanes.
    logic signed [PROD_W-1:0] r_prod [NUM_AXES];
    logic signed [ACC_W-1:0]  r_acc  [NUM_AXES];
    logic [REM_W-1:0]         r_rem  [NUM_AXES];
    logic [QUO_W-1:0]         r_quo  [NUM_AXES];
    logic [DIVC_W-1:0]        r_div_cnt;

    // Output register.
    logic   r_out_valid;
    t_coord r_out [NUM_AXES];
    logic   r_out_run_end;
    logic   r_out_path_end;

    // Next values and lane helpers.
    logic signed [COEF_W-1:0] n_c1 [NUM_AXES];
    logic signed [COEF_W-1:0] n_c2 [NUM_AXES];
    logic signed [COEF_W-1:0] n_c3 [NUM_AXES];
    t_coord                   n_p1 [NUM_AXES];
    logic signed [COEF_W-1:0] ea   [NUM_AXES];
    logic signed [COEF_W-1:0] eb   [NUM_AXES];
    logic signed [COEF_W-1:0] ec   [NUM_AXES];
    logic signed [COEF_W-1:0] ed   [NUM_AXES];
    logic [DEN_W-1:0]         trial   [NUM_AXES];
    logic                     quo_bit [NUM_AXES];
    logic [REM_W-1:0]         n_rem   [NUM_AXES];
    logic [RES_W-1:0]         sum     [NUM_AXES];
    t_coord                   n_res   [NUM_AXES];
    t_coord                   in_pos  [NUM_AXES];
    logic [N2_W-1:0]          n_n2;
    logic [S2_W-1:0]          n_s2;
    logic [WGT_W-1:0]         n_w1;
    logic [WGT_W-1:0]         n_w2;
    logic [WGT_W-1:0]         n_w3;
    logic [DEN_W-1:0]         n_cube;
    logic [DEN_W-1:0]         n_den;
    logic                     emit_any;

    assign in_pos[0] = i_pos_x;
    assign in_pos[1] = i_pos_y;
    assign in_pos[2] = i_pos_z;

    // Zero subdivisions act as one, large values saturate.
    always_comb begin
        if (r_subdiv == '0) begin
            n_eff = N_MIN;
        end else if (r_subdiv > N_MAX) begin
            n_eff = N_MAX;
        end else begin
            n_eff = r_subdiv;
        end
    end

    // Small multipliers for n^2, s^2, the three weights and the divisor 2n^3.
    always_comb begin
        n_n2   = N2_W'(n_eff) * N2_W'(n_eff);
        n_s2   = S2_W'(r_s) * S2_W'(r_s);
        n_w1   = WGT_W'(r_s) * WGT_W'(r_n2);
        n_cube = DEN_W'(r_n2) * DEN_W'(n_eff);
        n_den  = {n_cube[DEN_W-2:0], 1'b0};
        n_w2   = WGT_W'(r_s2) * WGT_W'(n_eff);
        n_w3   = WGT_W'(r_s2) * WGT_W'(r_s);
    end

    // Control points and coefficients for each axis.
    always_comb begin
        for (int l = 0; l < NUM_AXES; l++) begin
            if (i_cmd.seg2) begin
                ea[l]   = COEF_W'(r_hold[1][l]);
                eb[l]   = COEF_W'(r_hold[2][l]);
                ec[l]   = COEF_W'(r_cur[l]);
                n_p1[l] = r_hold[2][l];
            end else begin
                ea[l]   = i_cmd.p0_old ? COEF_W'(r_hold[0][l]) : COEF_W'(r_hold[1][l]);
                eb[l]   = COEF_W'(r_hold[1][l]);
                ec[l]   = COEF_W'(r_hold[2][l]);
                n_p1[l] = r_hold[1][l];
            end
            ed[l]   = COEF_W'(r_cur[l]);
            n_c1[l] = ec[l] - ea[l];
            n_c2[l] = (ea[l] <<< 1) - (eb[l] <<< 2) - eb[l] + (ec[l] <<< 2) - ed[l];
            n_c3[l] = ed[l] - ea[l] + (eb[l] <<< 1) + eb[l] - (ec[l] <<< 1) - ec[l];
        end
    end

    // Restoring divider step and final offset removal with saturation.
    always_comb begin
        for (int l = 0; l < NUM_AXES; l++) begin
            trial[l] = {r_rem[l], r_quo[l][QUO_W-1]};
            if (trial[l] >= r_den) begin
                quo_bit[l] = 1'b1;
                n_rem[l]   = REM_W'(trial[l] - r_den);
            end else begin
                quo_bit[l] = 1'b0;
                n_rem[l]   = REM_W'(trial[l]);
            end
            sum[l] = {{(RES_W-COORD_W){r_p1[l][COORD_W-1]}}, r_p1[l]}
                   + {2'b00, r_quo[l]} - QUO_OFS;
            if (!sum[l][RES_W-1] && (|sum[l][RES_W-2:COORD_W-1])) begin
                n_res[l] = {1'b0, {(COORD_W-1){1'b1}}};
            end else if (sum[l][RES_W-1] && !(&sum[l][RES_W-2:COORD_W-1])) begin
                n_res[l] = {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
                n_res[l] = sum[l][COORD_W-1:0];
            end
        end
    end

    assign emit_any = i_cmd.emit_sample || i_cmd.emit_prev || i_cmd.emit_cur;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subdiv    <= SUBDIV_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_subdiv <= i_cfg_data;
            end
            if (emit_any) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sample and divider counters, weights.
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_s  <= '0;
            r_n2 <= n_n2;
        end else if (i_cmd.s_inc) begin
            r_s <= r_s + S_W'(1);
        end
        if (i_cmd.wgt_a) begin
            r_s2  <= n_s2;
            r_w1  <= n_w1;
            r_den <= n_den;
        end
        if (i_cmd.wgt_b) begin
            r_w2 <= n_w2;
            r_w3 <= n_w3;
        end
        if (i_cmd.div_load) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + DIVC_W'(1);
        end
    end

    // Point window, coefficients, MAC and divider lanes, output payload.
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NUM_AXES; l++) begin
            if (i_cmd.load_cur) begin
                r_cur[l] <= in_pos[l];
            end
            if (i_cmd.shift) begin
                r_hold[0][l] <= r_hold[1][l];
                r_hold[1][l] <= r_hold[2][l];
                r_hold[2][l] <= r_cur[l];
            end
            if (i_cmd.setup) begin
                r_c1[l] <= n_c1[l];
                r_c2[l] <= n_c2[l];
                r_c3[l] <= n_c3[l];
                r_p1[l] <= n_p1[l];
            end
            // Weighted coefficient products, one per cycle, summed over the offset.
            if (i_cmd.wgt_b) begin
                r_prod[l] <= r_c1[l] * $signed({1'b0, r_w1});
                r_acc[l]  <= {{(ACC_W-DEN_W-QUO_W+1){1'b0}}, r_den, {(QUO_W-1){1'b0}}};
            end else if (i_cmd.mul2) begin
                r_prod[l] <= r_c2[l] * $signed({1'b0, r_w2});
                r_acc[l]  <= r_acc[l] + ACC_W'(r_prod[l]);
            end else if (i_cmd.mul3) begin
                r_prod[l] <= r_c3[l] * $signed({1'b0, r_w3});
                r_acc[l]  <= r_acc[l] + ACC_W'(r_prod[l]);
            end else if (i_cmd.acc_last) begin
                r_acc[l] <= r_acc[l] + ACC_W'(r_prod[l]);
            end
            if (i_cmd.div_load) begin
                r_rem[l] <= r_acc[l][QUO_W+REM_W-1:QUO_W];
                r_quo[l] <= r_acc[l][QUO_W-1:0];
            end else if (i_cmd.div_step) begin
                r_rem[l] <= n_rem[l];
                r_quo[l] <= {r_quo[l][QUO_W-2:0], quo_bit[l]};
            end
            if (i_cmd.emit_sample) begin
                r_out[l] <= n_res[l];
            end else if (i_cmd.emit_prev) begin
                r_out[l] <= r_hold[2][l];
            end else if (i_cmd.emit_cur) begin
                r_out[l] <= r_cur[l];
            end
        end
        if (emit_any) begin
            r_out_run_end  <= i_cmd.run_end;
            r_out_path_end <= i_cmd.path_end;
        end
    end

    assign o_stat.last_sample = (r_s == S_W'(n_eff - N_MIN));
    assign o_stat.div_last    = (r_div_cnt == DIV_LAST);
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out[0];
    assign o_out_y     = r_out[1];
    assign o_out_z     = r_out[2];
    assign o_run_end   = r_out_run_end;
    assign o_path_end  = r_out_path_end;

    // The axis 0 divider remainder stays below the divisor on every step.
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (DEN_W'(r_rem[0]) < r_den))
        else $error("divider remainder reached the divisor");

    // A word waiting at the output is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !emit_any)
        else $error("output word overwritten while stalled");

endmodule

// File: design/crps_ctrl.sv
// Controller: sequences segments, samples, pass-through words and window updates.
`timescale 1ns / 1ps
module crps_ctrl import crps_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_final_point,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SETUP,
        S_WGT_A,
        S_WGT_B,
        S_MUL2,
        S_MUL3,
        S_ACC,
        S_DIV_LOAD,
        S_DIV,
        S_EMIT,
        S_PASS_PREV,
        S_PASS_CUR,
        S_DONE
    } t_state;

    t_state     r_state, n_state;
    logic       r_fin, n_fin;
    logic       r_seg2, n_seg2;
    logic [1:0] r_pts_seen, n_pts_seen;
    logic       in_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;

    // Next state and command decode.
    always_comb begin
        n_state    = r_state;
        n_fin      = r_fin;
        n_seg2     = r_seg2;
        n_pts_seen = r_pts_seen;
        o_cmd      = '0;
        o_cmd.seg2   = r_seg2;
        o_cmd.p0_old = (r_pts_seen == 2'd3);
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    o_cmd.load_cur = 1'b1;
                    n_fin          = i_final_point;
                    n_state        = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_seg2 = 1'b0;
                if (r_pts_seen >= 2'd2) begin
                    n_state = S_SETUP;
                end else if (r_fin) begin
                    n_state = (r_pts_seen == 2'd1) ? S_PASS_PREV : S_PASS_CUR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_WGT_A;
            end
            S_WGT_A: begin
                o_cmd.wgt_a = 1'b1;
                n_state     = S_WGT_B;
            end
            S_WGT_B: begin
                o_cmd.wgt_b = 1'b1;
                n_state     = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.mul3 = 1'b1;
                n_state    = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_last = 1'b1;
                n_state        = S_DIV_LOAD;
            end
            S_DIV_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_sample = 1'b1;
                    o_cmd.run_end     = i_stat.last_sample && !r_seg2 && !r_fin;
                    if (!i_stat.last_sample) begin
                        o_cmd.s_inc = 1'b1;
                        n_state     = S_WGT_A;
                    end else if (r_seg2) begin
                        n_state = S_PASS_CUR;
                    end else if (r_fin) begin
                        // The closing segment repeats the last point as p3.
                        n_seg2  = 1'b1;
                        n_state = S_SETUP;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_PASS_PREV: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_prev = 1'b1;
                    n_state         = S_PASS_CUR;
                end
            end
            S_PASS_CUR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_cur = 1'b1;
                    o_cmd.run_end  = 1'b1;
                    o_cmd.path_end = r_fin;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.shift = !r_fin;
                if (r_fin) begin
                    n_pts_seen = 2'd0;
                end else if (r_pts_seen != 2'd3) begin
                    n_pts_seen = r_pts_seen + 2'd1;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fin      <= 1'b0;
            r_seg2     <= 1'b0;
            r_pts_seen <= 2'd0;
        end else begin
            r_state    <= n_state;
            r_fin      <= n_fin;
            r_seg2     <= n_seg2;
            r_pts_seen <= n_pts_seen;
        end
    end

    // Results are only written into a free output register.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_sample || o_cmd.emit_prev || o_cmd.emit_cur) |-> i_stat.out_free)
        else $error("result written while output register busy");

    // An accepted word is always followed by the decision step.
    a_accept_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_DECIDE))
        else $error("accepted word not followed by decision");

    // The point count only moves when a word is retired.
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DONE) |=> $stable(r_pts_seen))
        else $error("point count changed outside retire step");

endmodule

// File: design/catmull_rom_path_smoother.sv
// Top level of the uniform Catmull-Rom path smoother: controller, datapath and ports.
// Each sample runs through weights, three multiply-accumulate steps and a
// 36-step radix-2 divider by 2n^3, for the three axes in parallel lanes.
// A word that closes a segment holds the block until its samples are out, and a final
// word also runs the closing segment; no new word is accepted before the block is idle.
// Synchronous active-low reset empties the path and sets subdivisions to three.
`timescale 1ns / 1ps
module catmull_rom_path_smoother import crps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_coord           i_pos_x,
    input  t_coord           i_pos_y,
    input  t_coord           i_pos_z,
    input  logic             i_final_point,
    output logic             o_valid,
    input  logic             i_ready,
    output t_coord           o_out_x,
    output t_coord           o_out_y,
    output t_coord           o_out_z,
    output logic             o_run_end,
    output logic             o_path_end
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // The subdivision register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    crps_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .o_in_ready    (o_ready),
        .i_final_point (i_final_point),
        .o_cmd         (cmd),
        .i_stat        (stat)
    );

    crps_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_run_end   (o_run_end),
        .o_path_end  (o_path_end)
    );

endmodule

// File: test/tb.sv
// Self-checking testbench for the Catmull-Rom path smoother, with its own spline predictor.
`timescale 1ns / 1ps
module tb;
    import crps_pkg::*;

    localparam int     CLK_PERIOD    = 10;
    localparam longint CYCLE_LIMIT   = 4_000_000;
    localparam int     SETTLE_CYCLES = 100;
    localparam int     TAIL_CYCLES   = 200;
    localparam int     REPORT_MAX    = 10;
    localparam t_coord CMAX          = 32'sh7FFF_FFFF;
    localparam t_coord CMIN          = 32'sh8000_0000;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    typedef struct packed {
        t_point pos;
        logic   run_end;
        logic   path_end;
    } t_sample;

    typedef enum int {STYLE_SPREAD, STYLE_WALK, STYLE_CORNERS} t_style;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_valid;
    logic             o_ready;
    t_coord           i_pos_x;
    t_coord           i_pos_y;
    t_coord           i_pos_z;
    logic             i_final_point;
    logic             o_valid;
    logic             i_ready;
    t_coord           o_out_x;
    t_coord           o_out_y;
    t_coord           o_out_z;
    logic             o_run_end;
    logic             o_path_end;

    catmull_rom_path_smoother u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_final_point (i_final_point),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_run_end     (o_run_end),
        .o_path_end    (o_path_end)
    );

    // Predictor state: the subdivision register and the trail of earlier path points.
    logic [CFG_W-1:0] subdiv_shadow;
    t_point           trail [3];
    int               trail_len;
    t_sample          expected_samples [$];

    // Run statistics and flow control shared between processes.
    int     mismatches;
    int     samples_checked;
    int     points_sent;
    int     paths_closed;
    int     cfg_writes;
    longint cycle_count;
    int     rx_hold_cycles;
    bit     sender_steady;
    bit     receiver_steady;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles, %0d samples still outstanding.",
                         cycle_count, expected_samples.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Result side: random stalls, plus a long hold-off counted down here when requested.
    initial begin
        int gap_left;
        gap_left = 0;
        i_ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                i_ready = 1'b0;
                rx_hold_cycles--;
            end else if (receiver_steady) begin
                i_ready = 1'b1;
            end else if (gap_left > 0) begin
                i_ready = 1'b0;
                gap_left--;
            end else begin
                i_ready = 1'b1;
                if ($urandom_range(0, 3) == 0) gap_left = pick_gap();
            end
        end
    end

    // Compare every accepted result word with the oldest predicted sample.
    always @(posedge i_clk) begin
        t_sample want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("Unexpected sample at cycle %0d: x=%0d y=%0d z=%0d run=%b path=%b",
                             cycle_count, o_out_x, o_out_y, o_out_z, o_run_end, o_path_end);
            end else begin
                want = expected_samples.pop_front();
                samples_checked++;
                if (o_out_x !== want.pos.x || o_out_y !== want.pos.y ||
                    o_out_z !== want.pos.z || o_run_end !== want.run_end ||
                    o_path_end !== want.path_end) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("Sample %0d wrong at cycle %0d", samples_checked, cycle_count);
                        $display("  expected x=%0d y=%0d z=%0d run=%b path=%b",
                                 $signed(want.pos.x), $signed(want.pos.y),
                                 $signed(want.pos.z), want.run_end, want.path_end);
                        $display("  actual   x=%0d y=%0d z=%0d run=%b path=%b",
                                 o_out_x, o_out_y, o_out_z, o_run_end, o_path_end);
                    end
                end
            end
        end
    end

    // Samples per segment after clamping the register to 1..MAX_SUBDIV.
    function automatic int eff_subdiv(logic [CFG_W-1:0] value);
        if (value == 0) return 1;
        if (value > MAX_SUBDIV) return MAX_SUBDIV;
        return int'(value);
    endfunction

    // One axis of a uniform Catmull-Rom sample at t = s/n, floored, then clamped.
    function automatic t_coord blend_axis(t_coord a, t_coord b, t_coord c, t_coord e,
                                          int n, int s);
        longint pa, pb, pc, pe, ln, ls, c1, c2, c3, num, den, quo;
        pa  = a;
        pb  = b;
        pc  = c;
        pe  = e;
        ln  = n;
        ls  = s;
        c1  = pc - pa;
        c2  = 2 * pa - 5 * pb + 4 * pc - pe;
        c3  = -pa + 3 * pb - 3 * pc + pe;
        num = 2 * ln * ln * ln * pb + ln * ln * ls * c1 + ln * ls * ls * c2 + ls * ls * ls * c3;
        den = 2 * ln * ln * ln;
        quo = num / den;
        if (num % den < 0) quo = quo - 1;
        if (quo > longint'(CMAX)) quo = CMAX;
        if (quo < longint'(CMIN)) quo = CMIN;
        return t_coord'(quo);
    endfunction

    function automatic t_point blend_point(t_point a, t_point b, t_point c, t_point e,
                                           int n, int s);
        t_point p;
        p.x = blend_axis(a.x, b.x, c.x, e.x, n, s);
        p.y = blend_axis(a.y, b.y, c.y, e.y, n, s);
        p.z = blend_axis(a.z, b.z, c.z, e.z, n, s);
        return p;
    endfunction

    // Append one predicted sample at the tail of the queue.
    function automatic void queue_sample(t_sample w);
        expected_samples.insert(expected_samples.size(), w);
    endfunction

    function automatic void add_segment(t_point a, t_point b, t_point c, t_point e, int n);
        for (int s = 0; s < n; s++)
            queue_sample(t_sample'{blend_point(a, b, c, e, n, s), 1'b0, 1'b0});
    endfunction

    // Work out the samples that one accepted point causes and advance the path trail.
    function automatic void predict_point(t_point cur, logic fin);
        int     n;
        int     first;
        t_point p0;
        n     = eff_subdiv(subdiv_shadow);
        first = expected_samples.size();
        if (trail_len >= 2) begin
            // The segment between the two newest held points closes now; at the
            // path start the first point stands in for the missing p0.
            p0 = (trail_len >= 3) ? trail[0] : trail[1];
            add_segment(p0, trail[1], trail[2], cur, n);
            if (fin) begin
                add_segment(trail[1], trail[2], cur, cur, n);
                queue_sample(t_sample'{cur, 1'b0, 1'b0});
            end
        end else if (fin) begin
            // Paths of one or two points pass through unchanged.
            if (trail_len == 1) queue_sample(t_sample'{trail[2], 1'b0, 1'b0});
            queue_sample(t_sample'{cur, 1'b0, 1'b0});
        end
        if (expected_samples.size() > first) begin
            expected_samples[expected_samples.size() - 1].run_end  = 1'b1;
            expected_samples[expected_samples.size() - 1].path_end = fin;
        end
        if (fin) begin
            trail_len = 0;
        end else begin
            trail[0] = trail[1];
            trail[1] = trail[2];
            trail[2] = cur;
            if (trail_len < 3) trail_len++;
        end
    endfunction

    function automatic t_point pt(t_coord x, t_coord y, t_coord z);
        t_point p;
        p.x = x;
        p.y = y;
        p.z = z;
        return p;
    endfunction

    function automatic t_coord pick_corner();
        case ($urandom_range(0, 3))
            0:       return CMAX;
            1:       return CMIN;
            2:       return t_coord'(0);
            default: return t_coord'(-1);
        endcase
    endfunction

    function automatic t_coord walk_step(t_coord from);
        return from + t_coord'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
    endfunction

    // Next point of a generated path in the given style.
    function automatic t_point next_point(t_style style, t_point prev);
        case (style)
            STYLE_WALK:
                return pt(walk_step(prev.x), walk_step(prev.y), walk_step(prev.z));
            STYLE_CORNERS:
                return pt(pick_corner(), pick_corner(), pick_corner());
            default:
                return pt(t_coord'($urandom), t_coord'($urandom), t_coord'($urandom));
        endcase
    endfunction

    // Offer one point word and wait for it to be taken; valid stays up when no gap follows.
    task automatic send_point(t_point p, logic fin);
        int gap;
        @(negedge i_clk);
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_pos_x       = p.x;
        i_pos_y       = p.y;
        i_pos_z       = p.z;
        i_final_point = fin;
        i_valid       = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_point(p, fin);
        points_sent++;
        if (fin) paths_closed++;
    endtask

    task automatic send_path(int len, t_style style, bit terminate);
        t_point p;
        p = pt(t_coord'($urandom), t_coord'($urandom), t_coord'($urandom));
        for (int k = 0; k < len; k++) begin
            p = next_point(style, p);
            send_point(p, terminate && (k == len - 1));
        end
    endtask

    // Stop offering words, wait for every predicted sample, then let the block go quiet.
    task automatic settle_block();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_subdiv(logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        subdiv_shadow = value;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Reset value of three: single-point, two-point and three-point paths.
    task automatic test_short_paths();
        send_point(pt(CMAX, CMIN, 32'sd0), 1'b1);
        send_point(pt(32'sd1, 32'sd2, 32'sd3), 1'b0);
        send_point(pt(-32'sd1, -32'sd2, -32'sd3), 1'b1);
        send_point(pt(32'sd0, 32'sd0, 32'sd0), 1'b0);
        send_point(pt(32'sd655360, 32'sd0, -32'sd327680), 1'b0);
        send_point(pt(32'sd1310720, 32'sd196608, 32'sd458752), 1'b1);
        settle_block();
    endtask

    // Alternating range ends make the curve overshoot, so samples clamp; a register
    // value above the maximum saturates to sixteen samples.
    task automatic test_overshoot_clamp();
        write_subdiv(CFG_W'(31));
        send_point(pt(CMIN, CMAX, CMIN), 1'b0);
        send_point(pt(CMAX, CMIN, CMAX), 1'b0);
        send_point(pt(CMAX, CMIN, CMAX), 1'b0);
        send_point(pt(CMIN, CMAX, CMIN), 1'b1);
        settle_block();
    endtask

    // A register value of zero acts as one sample per segment; then the smallest legal value.
    task automatic test_min_subdiv();
        write_subdiv(CFG_W'(0));
        send_point(pt(32'sd0, 32'sd0, 32'sd0), 1'b0);
        send_point(pt(-32'sd1, -32'sd1, -32'sd1), 1'b0);
        send_point(pt(CMAX, CMAX, CMAX), 1'b0);
        send_point(pt(CMIN, CMIN, CMIN), 1'b0);
        send_point(pt(32'sd1, -32'sd65536, 32'sd65536), 1'b1);
        settle_block();
        write_subdiv(CFG_W'(1));
        send_point(pt(32'sd100, 32'sd200, 32'sd300), 1'b0);
        send_point(pt(-32'sd400, 32'sd500, -32'sd600), 1'b0);
        send_point(pt(32'sd700, -32'sd800, 32'sd900), 1'b1);
        settle_block();
    endtask

    // Receiver holds off for a long stretch while points keep coming, so the block fills.
    task automatic test_output_backpressure();
        t_point p;
        write_subdiv(CFG_W'(8));
        rx_hold_cycles = 3000;
        sender_steady  = 1'b1;
        p = pt(32'sd0, 32'sd0, 32'sd0);
        for (int k = 0; k < 12; k++) begin
            p = next_point(STYLE_WALK, p);
            send_point(p, k == 11);
        end
        sender_steady = 1'b0;
        settle_block();
    endtask

    // Both sides at full rate with no idle cycles.
    task automatic test_steady_stream();
        int start;
        write_subdiv(CFG_W'(2));
        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        start = points_sent;
        while (points_sent - start < 30)
            send_path($urandom_range(1, 8), t_style'($urandom_range(0, 2)), 1'b1);
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        settle_block();
    endtask

    // Random paths over random register settings, mostly small subdivision counts.
    task automatic test_random_paths(int target);
        int               start;
        int               phase_start;
        int               phase_items;
        int               roll;
        int               len;
        logic [CFG_W-1:0] cfg;
        start = points_sent;
        while (points_sent - start < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 8)       cfg = CFG_W'($urandom_range(16, 31));
            else if (roll < 13) cfg = '0;
            else                cfg = CFG_W'($urandom_range(1, 6));
            write_subdiv(cfg);
            phase_items = (eff_subdiv(cfg) > 8) ? 12 : 45;
            phase_start = points_sent;
            while (points_sent - phase_start < phase_items) begin
                roll = $urandom_range(0, 99);
                if (roll < 15)      len = $urandom_range(1, 2);
                else if (roll < 85) len = $urandom_range(3, 10);
                else                len = $urandom_range(11, 24);
                // Most paths are closed; an open one runs on into the next path, maybe under the next setting.
                send_path(len, t_style'($urandom_range(0, 2)), $urandom_range(0, 9) != 0);
            end
            settle_block();
        end
    endtask

    // Test sequence.
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        i_valid         = 1'b0;
        i_pos_x         = '0;
        i_pos_y         = '0;
        i_pos_z         = '0;
        i_final_point   = 1'b0;
        subdiv_shadow   = SUBDIV_RST;
        trail_len       = 0;
        mismatches      = 0;
        samples_checked = 0;
        points_sent     = 0;
        paths_closed    = 0;
        cfg_writes      = 0;
        rx_hold_cycles  = 0;
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_short_paths();
        test_overshoot_clamp();
        test_min_subdiv();
        test_output_backpressure();
        test_steady_stream();
        test_random_paths(290);

        settle_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d points in %0d closed paths and %0d register writes,",
                 points_sent, paths_closed, cfg_writes);
        $display("with %0d smoothed samples checked and %0d mismatches.",
                 samples_checked, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
